// ===== hdl/qwt_pkg.sv =====
package qwt_pkg;

  localparam int unsigned MODE_W = 7;
  localparam int unsigned RES_MAX = 3;
  localparam int unsigned SEP_REGS = 4;

  localparam int unsigned MODE_UNQUOTE = 0;
  localparam int unsigned MODE_KEEP_QUOTE = 1;
  localparam int unsigned MODE_RELAX = 2;
  localparam int unsigned MODE_UNESC_RELAX = 3;
  localparam int unsigned MODE_UNESC_SEP = 4;
  localparam int unsigned MODE_RETAIN_ESC = 5;
  localparam int unsigned MODE_NO_COALESCE = 6;

  localparam logic [2:0] KIND_BYTE = 3'd0;
  localparam logic [2:0] KIND_WORD_END = 3'd1;
  localparam logic [2:0] KIND_TEXT_END = 3'd2;
  localparam logic [2:0] KIND_BAD_ESCAPE = 3'd3;
  localparam logic [2:0] KIND_UNBALANCED = 3'd4;

  localparam logic [1:0] QUOTE_NONE = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [2:0] CFG_MODE = 3'd0;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_SQUOTE = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;

  localparam logic [7:0] SEP_RESET [SEP_REGS] = '{8'd32, 8'd9, 8'd10, 8'd13};

  typedef struct packed {
    logic [1:0] quote;
    logic       esc;
    logic       open;
    logic       started;
    logic       err;
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } res_t;

endpackage

// ===== hdl/qwt_step.sv =====
module qwt_step (
  input  qwt_pkg::state_t                       state_i,
  input  logic [qwt_pkg::MODE_W-1:0]            mode_i,
  input  logic [7:0]                            byte_i,
  input  logic                                  is_sep_i,
  output qwt_pkg::state_t                       state_o,
  output qwt_pkg::res_t [qwt_pkg::RES_MAX-1:0]  res_o,
  output logic [1:0]                            count_o
);
  import qwt_pkg::*;

  state_t                 ns;
  res_t [RES_MAX-1:0]     res;
  logic [1:0]             n;
  state_t                 fresh;
  logic                   relax;
  logic                   unrelax;
  logic                   is_nul;
  logic                   is_bs;
  logic [7:0]             qc;

  always_comb begin
    relax = mode_i[MODE_RELAX];
    unrelax = mode_i[MODE_UNESC_RELAX];
    is_nul = (byte_i == CHAR_NUL);
    is_bs = (byte_i == CHAR_BACKSLASH) && !mode_i[MODE_RETAIN_ESC];
    qc = (state_i.quote == QUOTE_SINGLE) ? CHAR_SQUOTE : CHAR_DQUOTE;

    fresh = '0;
    fresh.open = mode_i[MODE_NO_COALESCE];

    ns = state_i;
    res = '0;
    n = 2'd0;

    if (state_i.err) begin
      if (is_nul) begin
        res[n] = '{kind: KIND_TEXT_END, data: 8'h00};
        n = n + 2'd1;
        ns = fresh;
      end
    end else if (!state_i.started && is_nul) begin
      if (state_i.open) begin
        res[n] = '{kind: KIND_WORD_END, data: 8'h00};
        n = n + 2'd1;
      end
      res[n] = '{kind: KIND_TEXT_END, data: 8'h00};
      n = n + 2'd1;
      ns = fresh;
    end else if (!state_i.started && is_sep_i) begin
      if (mode_i[MODE_NO_COALESCE]) begin
        res[n] = '{kind: KIND_WORD_END, data: 8'h00};
        n = n + 2'd1;
        ns.open = 1'b1;
      end
    end else begin
      ns.started = 1'b1;
      if (state_i.esc) begin
        if (is_nul) begin
          if (unrelax && (state_i.quote == QUOTE_NONE || relax)) begin
            res[n] = '{kind: KIND_BYTE, data: CHAR_BACKSLASH};
            n = n + 2'd1;
            res[n] = '{kind: KIND_WORD_END, data: 8'h00};
            n = n + 2'd1;
          end else if (relax) begin
            res[n] = '{kind: KIND_WORD_END, data: 8'h00};
            n = n + 2'd1;
          end else begin
            res[n] = '{kind: (state_i.quote != QUOTE_NONE) ? KIND_UNBALANCED : KIND_BAD_ESCAPE,
                       data: 8'h00};
            n = n + 2'd1;
          end
          res[n] = '{kind: KIND_TEXT_END, data: 8'h00};
          n = n + 2'd1;
          ns = fresh;
        end else begin
          ns.esc = 1'b0;
          if (mode_i[MODE_UNESC_SEP]) begin
            if (is_sep_i || byte_i == CHAR_BACKSLASH) begin
              res[n] = '{kind: KIND_BYTE, data: byte_i};
              n = n + 2'd1;
            end else if (unrelax) begin
              res[n] = '{kind: KIND_BYTE, data: CHAR_BACKSLASH};
              n = n + 2'd1;
              res[n] = '{kind: KIND_BYTE, data: byte_i};
              n = n + 2'd1;
            end else begin
              res[n] = '{kind: KIND_BAD_ESCAPE, data: 8'h00};
              n = n + 2'd1;
              ns = '0;
              ns.err = 1'b1;
            end
          end else begin
            res[n] = '{kind: KIND_BYTE, data: byte_i};
            n = n + 2'd1;
          end
        end
      end else if (state_i.quote != QUOTE_NONE) begin
        if (is_nul) begin
          res[n] = '{kind: relax ? KIND_WORD_END : KIND_UNBALANCED, data: 8'h00};
          n = n + 2'd1;
          res[n] = '{kind: KIND_TEXT_END, data: 8'h00};
          n = n + 2'd1;
          ns = fresh;
        end else if (byte_i == qc) begin
          ns.quote = QUOTE_NONE;
          if (!mode_i[MODE_UNQUOTE]) begin
            res[n] = '{kind: KIND_BYTE, data: byte_i};
            n = n + 2'd1;
          end
        end else if (is_bs) begin
          ns.esc = 1'b1;
        end else begin
          res[n] = '{kind: KIND_BYTE, data: byte_i};
          n = n + 2'd1;
        end
      end else begin
        if (is_nul) begin
          res[n] = '{kind: KIND_WORD_END, data: 8'h00};
          n = n + 2'd1;
          res[n] = '{kind: KIND_TEXT_END, data: 8'h00};
          n = n + 2'd1;
          ns = fresh;
        end else if ((byte_i == CHAR_SQUOTE || byte_i == CHAR_DQUOTE) &&
                     (mode_i[MODE_KEEP_QUOTE] || mode_i[MODE_UNQUOTE])) begin
          ns.quote = (byte_i == CHAR_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
          if (!mode_i[MODE_UNQUOTE]) begin
            res[n] = '{kind: KIND_BYTE, data: byte_i};
            n = n + 2'd1;
          end
        end else if (is_bs) begin
          ns.esc = 1'b1;
        end else if (is_sep_i) begin
          res[n] = '{kind: KIND_WORD_END, data: 8'h00};
          n = n + 2'd1;
          ns.started = 1'b0;
          ns.open = mode_i[MODE_NO_COALESCE];
        end else begin
          res[n] = '{kind: KIND_BYTE, data: byte_i};
          n = n + 2'd1;
        end
      end
    end
  end

  assign state_o = ns;
  assign res_o = res;
  assign count_o = n;

endmodule

// ===== hdl/quoted_word_tokenizer.sv =====
// An accepted byte is registered in the input register and its results in the result buffer.
// One item per cycle while each item gives at most one result and the output is not stalled;
// an item that gives k results holds the result buffer, and so the input, until all k are taken.
// Reset clears the quote, escape, word and error state, sets the mode to zero and
// loads the default separators (space, tab, line feed, carriage return).
module quoted_word_tokenizer #(
  parameter int unsigned SEPARATOR_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] word_byte_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import qwt_pkg::*;

  localparam int unsigned SepStored = (SEPARATOR_COUNT < SEP_REGS) ? SEPARATOR_COUNT : SEP_REGS;

  logic [MODE_W-1:0]    mode_q;
  logic [7:0]           sep_q [SepStored];
  state_t               state_q;
  state_t               state_d;
  logic [7:0]           byte_q;
  logic                 byte_vq;
  res_t [RES_MAX-1:0]   res_q;
  res_t [RES_MAX-1:0]   res_d;
  logic [1:0]           count_d;
  logic [1:0]           rem_q;
  logic [1:0]           idx_q;
  logic                 is_sep;
  logic                 pop;
  logic                 load;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_comb begin
    is_sep = 1'b0;
    for (int j = 0; j < SepStored; j++) begin
      if (sep_q[j] != CHAR_NUL && sep_q[j] == byte_q) begin
        is_sep = 1'b1;
      end
    end
  end

  qwt_step u_step (
    .state_i  (state_q),
    .mode_i   (mode_q),
    .byte_i   (byte_q),
    .is_sep_i (is_sep),
    .state_o  (state_d),
    .res_o    (res_d),
    .count_o  (count_d)
  );

  assign out_valid_o = (rem_q != 2'd0);
  assign kind_o = res_q[idx_q].kind;
  assign word_byte_o = res_q[idx_q].data;
  assign last_o = (rem_q == 2'd1);

  assign pop = out_valid_o && !out_stall_i;
  assign load = byte_vq && (rem_q == 2'd0 || (rem_q == 2'd1 && pop));
  assign in_stall_o = byte_vq && !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      for (int j = 0; j < SepStored; j++) begin
        sep_q[j] <= SEP_RESET[j];
      end
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_MODE) begin
        mode_q <= cfg_data_i[MODE_W-1:0];
      end
      for (int j = 0; j < SepStored; j++) begin
        if (cfg_index_i == 3'(j + 1)) begin
          sep_q[j] <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (load) begin
      state_q <= state_d;
    end else if (cfg_we && cfg_index_i == CFG_MODE && !state_q.started) begin
      state_q.open <= cfg_data_i[MODE_NO_COALESCE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vq <= 1'b0;
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        byte_vq <= 1'b1;
      end else if (load) begin
        byte_vq <= 1'b0;
      end
      if (load) begin
        rem_q <= count_d;
        idx_q <= 2'd0;
      end else if (pop) begin
        rem_q <= rem_q - 2'd1;
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= text_byte_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTH
  a_text_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TEXT_END |-> last_o)
    else $error("text end is not the final result of its item");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> byte_vq)
    else $error("input stalled with an empty input register");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err |-> (state_q.quote == QUOTE_NONE && !state_q.esc && !state_q.started))
    else $error("error latched with word state still open");

  a_load_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && count_d == 2'd0 |=> !out_valid_o)
    else $error("result shown for an item that gives none");
`endif

endmodule
